@@ rtl/core/tfcm_pkg.sv @@
// ----------------------------------------------------------------------------
// tfcm_pkg
// Shared widths, register codes, color levels and stage types for the
// temperature false-color map.
// ----------------------------------------------------------------------------
package tfcm_pkg;

   localparam int TEMP_WIDTH = 16;
   localparam int THR_W      = 15;
   localparam int CMP_W      = (TEMP_WIDTH > THR_W) ? TEMP_WIDTH : THR_W;
   localparam int QUO_W      = 8;
   // numerator 2*k*x + d with k <= 255 and x <= d < 2^THR_W
   localparam int NUM_W      = THR_W + 9;
   // divisor 2*d aligned to the top quotient bit
   localparam int DSH_W      = THR_W + QUO_W;
   localparam int DIV_STEPS  = QUO_W / 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = THR_W;

   localparam logic [CSR_IDX_W-1:0] CSR_DISCRETE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIDDLE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_THIRD    = 3'd4;

   localparam logic             RST_DISCRETE = 1'b1;
   localparam logic [THR_W-1:0] RST_FIRST    = 15'd512;
   localparam logic [THR_W-1:0] RST_MIDDLE   = 15'd1280;
   localparam logic [THR_W-1:0] RST_SECOND   = 15'd2560;
   localparam logic [THR_W-1:0] RST_THIRD    = 15'd5120;

   localparam logic [7:0] LEVEL_FULL       = 8'd255;
   localparam logic [7:0] LEVEL_ZERO       = 8'd0;
   localparam logic [7:0] LEVEL_HALF       = 8'd127;
   localparam logic [7:0] LEVEL_DISC_MAIN  = 8'd192;
   localparam logic [7:0] SLOPE_FULL       = 8'd255;
   localparam logic [7:0] SLOPE_HIGH       = 8'd128;

   typedef enum logic [1:0] {
      SEG_LOW,
      SEG_MID,
      SEG_HIGH,
      SEG_TOP
   } seg_type;

   typedef struct packed {
      logic             discrete;
      logic [THR_W-1:0] first;
      logic [THR_W-1:0] middle;
      logic [THR_W-1:0] second;
      logic [THR_W-1:0] third;
   } cfg_type;

   typedef struct packed {
      logic    zero;
      logic    positive;
      seg_type seg;
      logic    discrete;
      logic    green_half;
   } meta_type;

   typedef struct packed {
      logic [NUM_W-1:0] rem;
      logic [DSH_W-1:0] dsh;
      logic [QUO_W-1:0] quo;
   } div_type;

endpackage

@@ rtl/core/temperature_false_color_map.sv @@
// ----------------------------------------------------------------------------
// temperature_false_color_map
// Signed Q8.8 temperature sample in, RGB false color out.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_ready   req_temperature
//   rsp      out        rsp_valid/rsp_ready   rsp_red, rsp_green, rsp_blue
//   csr      in         csr_write_enable      csr_index, csr_data
//
// One item per cycle unless the output stalls. Stages: magnitude, segment select,
// numerator, four two-bit divider stages for the rounded ramp, output register.
// Reset clears all stage valid bits and loads the register defaults.
// Each stage loads when empty or when the stage after it moves, so bubbles
// close up under a stalled output and no item is dropped or repeated.
// ----------------------------------------------------------------------------
module temperature_false_color_map (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [tfcm_pkg::TEMP_WIDTH-1:0] req_temperature,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [7:0]                             rsp_red,
   output logic [7:0]                             rsp_green,
   output logic [7:0]                             rsp_blue,
   input  logic                                   csr_write_enable,
   input  logic [tfcm_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [tfcm_pkg::CSR_DATA_W-1:0]        csr_data
);
   import tfcm_pkg::*;

   cfg_type          cfg_ff, cfg_in;

   logic             cls_valid, cls_ready;
   meta_type         cls_meta;
   logic [THR_W-1:0] cls_dist, cls_width;

   logic             div_valid, div_ready;
   meta_type         div_meta;
   logic [QUO_W-1:0] div_quo;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DISCRETE: cfg_in.discrete = csr_data[0];
            CSR_FIRST:    cfg_in.first    = csr_data;
            CSR_MIDDLE:   cfg_in.middle   = csr_data;
            CSR_SECOND:   cfg_in.second   = csr_data;
            CSR_THIRD:    cfg_in.third    = csr_data;
            default:      cfg_in          = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.discrete <= RST_DISCRETE;
         cfg_ff.first    <= RST_FIRST;
         cfg_ff.middle   <= RST_MIDDLE;
         cfg_ff.second   <= RST_SECOND;
         cfg_ff.third    <= RST_THIRD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tfcm_classify u_classify (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .up_valid    (req_valid),
      .up_ready    (req_ready),
      .temperature (req_temperature),
      .dn_valid    (cls_valid),
      .dn_ready    (cls_ready),
      .dn_meta     (cls_meta),
      .dn_dist     (cls_dist),
      .dn_width    (cls_width)
   );

   tfcm_ramp_div u_ramp_div (
      .clock    (clock),
      .reset    (reset),
      .up_valid (cls_valid),
      .up_ready (cls_ready),
      .up_meta  (cls_meta),
      .up_dist  (cls_dist),
      .up_width (cls_width),
      .dn_valid (div_valid),
      .dn_ready (div_ready),
      .dn_meta  (div_meta),
      .dn_quo   (div_quo)
   );

   tfcm_compose u_compose (
      .clock     (clock),
      .reset     (reset),
      .up_valid  (div_valid),
      .up_ready  (div_ready),
      .up_meta   (div_meta),
      .up_quo    (div_quo),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_red   (rsp_red),
      .rsp_green (rsp_green),
      .rsp_blue  (rsp_blue)
   );

endmodule

@@ rtl/core/tfcm_classify.sv @@
// ----------------------------------------------------------------------------
// tfcm_classify
// Two stages: magnitude and sign, then segment selection with the ramp
// distance and segment width.
// ----------------------------------------------------------------------------
module tfcm_classify (
   input  logic                                clock,
   input  logic                                reset,
   input  tfcm_pkg::cfg_type                   cfg,
   input  logic                                up_valid,
   output logic                                up_ready,
   input  logic signed [tfcm_pkg::TEMP_WIDTH-1:0] temperature,
   output logic                                dn_valid,
   input  logic                                dn_ready,
   output tfcm_pkg::meta_type                  dn_meta,
   output logic [tfcm_pkg::THR_W-1:0]          dn_dist,
   output logic [tfcm_pkg::THR_W-1:0]          dn_width
);
   import tfcm_pkg::*;

   logic                  s1_valid_ff, s1_valid_in;
   logic [TEMP_WIDTH-1:0] mag_ff, mag_in;
   logic                  zero_ff, zero_in;
   logic                  pos_ff, pos_in;
   logic                  s1_load;

   logic                  s2_valid_ff, s2_valid_in;
   meta_type              meta_ff, meta_in;
   logic [THR_W-1:0]      dist_ff, dist_in;
   logic [THR_W-1:0]      width_ff, width_in;
   logic                  s2_load;

   logic [TEMP_WIDTH-1:0] raw;
   logic [CMP_W-1:0]      m_ext, t1_ext, tm_ext, t2_ext, t3_ext;
   logic [CMP_W-1:0]      past_first, past_second;
   logic                  le_first, le_second, le_third;

   assign s2_load  = !s2_valid_ff || dn_ready;
   assign s1_load  = !s1_valid_ff || s2_load;
   assign up_ready = s1_load;

   // stage 1: magnitude, most negative sample stays exact as unsigned
   always_comb begin
      raw         = temperature;
      s1_valid_in = up_valid;
      zero_in     = (raw == '0);
      pos_in      = !raw[TEMP_WIDTH-1];
      mag_in      = raw[TEMP_WIDTH-1] ? (~raw + TEMP_WIDTH'(1)) : raw;
   end

   // stage 2: segment and ramp operands
   always_comb begin
      m_ext       = CMP_W'(mag_ff);
      t1_ext      = CMP_W'(cfg.first);
      tm_ext      = CMP_W'(cfg.middle);
      t2_ext      = CMP_W'(cfg.second);
      t3_ext      = CMP_W'(cfg.third);
      le_first    = (m_ext <= t1_ext);
      le_second   = (m_ext <= t2_ext);
      le_third    = (m_ext <= t3_ext);
      past_first  = m_ext - t1_ext;
      past_second = m_ext - t2_ext;

      s2_valid_in         = s1_valid_ff;
      meta_in.zero        = zero_ff;
      meta_in.positive    = pos_ff;
      meta_in.discrete    = cfg.discrete;
      meta_in.green_half  = (m_ext <= tm_ext);
      dist_in             = '0;
      width_in            = '0;
      if (le_first) begin
         meta_in.seg = SEG_LOW;
         dist_in     = m_ext[THR_W-1:0];
         width_in    = cfg.first;
      end else if (le_second) begin
         meta_in.seg = SEG_MID;
         dist_in     = past_first[THR_W-1:0];
         width_in    = cfg.second - cfg.first;
      end else if (le_third) begin
         meta_in.seg = SEG_HIGH;
         dist_in     = past_second[THR_W-1:0];
         width_in    = cfg.third - cfg.second;
      end else begin
         meta_in.seg = SEG_TOP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_load) s1_valid_ff <= s1_valid_in;
         if (s2_load) s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         mag_ff  <= mag_in;
         zero_ff <= zero_in;
         pos_ff  <= pos_in;
      end
      if (s2_load) begin
         meta_ff  <= meta_in;
         dist_ff  <= dist_in;
         width_ff <= width_in;
      end
   end

   assign dn_valid = s2_valid_ff;
   assign dn_meta  = meta_ff;
   assign dn_dist  = dist_ff;
   assign dn_width = width_ff;

endmodule

@@ rtl/core/tfcm_div_step.sv @@
// ----------------------------------------------------------------------------
// tfcm_div_step
// One registered stage of the restoring divider: two quotient bits.
// ----------------------------------------------------------------------------
module tfcm_div_step (
   input  logic               clock,
   input  logic               reset,
   input  logic               up_valid,
   output logic               up_ready,
   input  tfcm_pkg::meta_type up_meta,
   input  tfcm_pkg::div_type  up_div,
   output logic               dn_valid,
   input  logic               dn_ready,
   output tfcm_pkg::meta_type dn_meta,
   output tfcm_pkg::div_type  dn_div
);
   import tfcm_pkg::*;

   logic             valid_ff, valid_in;
   meta_type         meta_ff, meta_in;
   div_type          div_ff, div_in;
   logic             load;
   logic [NUM_W-1:0] sub_hi, sub_lo, rem_mid;
   logic             bit_hi, bit_lo;

   assign load     = !valid_ff || dn_ready;
   assign up_ready = load;

   always_comb begin
      sub_hi  = NUM_W'(up_div.dsh);
      bit_hi  = (sub_hi <= up_div.rem);
      rem_mid = bit_hi ? (up_div.rem - sub_hi) : up_div.rem;
      sub_lo  = NUM_W'(up_div.dsh >> 1);
      bit_lo  = (sub_lo <= rem_mid);

      valid_in   = up_valid;
      meta_in    = up_meta;
      div_in.rem = bit_lo ? (rem_mid - sub_lo) : rem_mid;
      div_in.dsh = up_div.dsh >> 2;
      div_in.quo = {up_div.quo[QUO_W-3:0], bit_hi, bit_lo};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         meta_ff <= meta_in;
         div_ff  <= div_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_meta  = meta_ff;
   assign dn_div   = div_ff;

endmodule

@@ rtl/core/tfcm_ramp_div.sv @@
// ----------------------------------------------------------------------------
// tfcm_ramp_div
// Rounded ramp fraction floor((2*k*x + d) / (2*d)): a numerator stage
// followed by a chain of two-bit divider stages.
// ----------------------------------------------------------------------------
module tfcm_ramp_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         up_valid,
   output logic                         up_ready,
   input  tfcm_pkg::meta_type           up_meta,
   input  logic [tfcm_pkg::THR_W-1:0]   up_dist,
   input  logic [tfcm_pkg::THR_W-1:0]   up_width,
   output logic                         dn_valid,
   input  logic                         dn_ready,
   output tfcm_pkg::meta_type           dn_meta,
   output logic [tfcm_pkg::QUO_W-1:0]   dn_quo
);
   import tfcm_pkg::*;

   logic               num_valid_ff, num_valid_in;
   meta_type           num_meta_ff, num_meta_in;
   div_type            num_div_ff, num_div_in;
   logic               num_load;
   logic [7:0]         slope;
   logic [THR_W+7:0]   prod;

   logic     vld [DIV_STEPS+1];
   logic     rdy [DIV_STEPS+1];
   meta_type meta_a [DIV_STEPS+1];
   div_type  div_a [DIV_STEPS+1];

   assign num_load = !num_valid_ff || rdy[0];
   assign up_ready = num_load;

   always_comb begin
      slope          = (up_meta.seg == SEG_HIGH) ? SLOPE_HIGH : SLOPE_FULL;
      prod           = (THR_W+8)'(up_dist) * (THR_W+8)'(slope);
      num_valid_in   = up_valid;
      num_meta_in    = up_meta;
      num_div_in.rem = NUM_W'({prod, 1'b0}) + NUM_W'(up_width);
      num_div_in.dsh = {up_width, {QUO_W{1'b0}}};
      num_div_in.quo = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_valid_ff <= 1'b0;
      end else if (num_load) begin
         num_valid_ff <= num_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (num_load) begin
         num_meta_ff <= num_meta_in;
         num_div_ff  <= num_div_in;
      end
   end

   assign vld[0]    = num_valid_ff;
   assign meta_a[0] = num_meta_ff;
   assign div_a[0]  = num_div_ff;

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
      tfcm_div_step u_step (
         .clock    (clock),
         .reset    (reset),
         .up_valid (vld[i]),
         .up_ready (rdy[i]),
         .up_meta  (meta_a[i]),
         .up_div   (div_a[i]),
         .dn_valid (vld[i+1]),
         .dn_ready (rdy[i+1]),
         .dn_meta  (meta_a[i+1]),
         .dn_div   (div_a[i+1])
      );
   end

   assign rdy[DIV_STEPS] = dn_ready;
   assign dn_valid       = vld[DIV_STEPS];
   assign dn_meta        = meta_a[DIV_STEPS];
   assign dn_quo         = div_a[DIV_STEPS].quo;

endmodule

@@ rtl/core/tfcm_compose.sv @@
// ----------------------------------------------------------------------------
// tfcm_compose
// Output stage: picks levels per segment and mode, swaps red and blue for
// negative samples, gives white for a zero sample, and holds the result until it is taken.
// ----------------------------------------------------------------------------
module tfcm_compose (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       up_valid,
   output logic                       up_ready,
   input  tfcm_pkg::meta_type         up_meta,
   input  logic [tfcm_pkg::QUO_W-1:0] up_quo,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [7:0]                 rsp_red,
   output logic [7:0]                 rsp_green,
   output logic [7:0]                 rsp_blue
);
   import tfcm_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] red_ff, red_in;
   logic [7:0] green_ff, green_in;
   logic [7:0] blue_ff, blue_in;
   logic       load;
   logic [7:0] ramp_level;
   logic [7:0] main_ch, green_ch, third_ch;

   assign load     = !valid_ff || rsp_ready;
   assign up_ready = load;

   always_comb begin
      ramp_level = LEVEL_FULL - 8'(up_quo);
      main_ch    = LEVEL_FULL;
      green_ch   = LEVEL_FULL;
      third_ch   = LEVEL_FULL;
      case (up_meta.seg)
         SEG_LOW: begin
            third_ch = up_meta.discrete ? LEVEL_ZERO : ramp_level;
         end
         SEG_MID: begin
            third_ch = LEVEL_ZERO;
            if (up_meta.discrete) begin
               green_ch = up_meta.green_half ? LEVEL_HALF : LEVEL_ZERO;
            end else begin
               green_ch = ramp_level;
            end
         end
         SEG_HIGH: begin
            third_ch = LEVEL_ZERO;
            green_ch = LEVEL_ZERO;
            main_ch  = up_meta.discrete ? LEVEL_DISC_MAIN : ramp_level;
         end
         default: begin
            third_ch = LEVEL_ZERO;
            green_ch = LEVEL_ZERO;
            main_ch  = LEVEL_HALF;
         end
      endcase

      valid_in = up_valid;
      if (up_meta.zero) begin
         red_in   = LEVEL_FULL;
         green_in = LEVEL_FULL;
         blue_in  = LEVEL_FULL;
      end else begin
         red_in   = up_meta.positive ? main_ch : third_ch;
         green_in = green_ch;
         blue_in  = up_meta.positive ? third_ch : main_ch;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb - temperature false-color map testbench
// Drives signed Q8.8 samples through the valid/ready input and checks every
// RGB result in order against a local color predictor. Covers both modes,
// threshold edges, odd register settings, output stalls and random traffic.
// ----------------------------------------------------------------------------
module tb;
   import tfcm_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 12;
   localparam int REPORT_MAX   = 10;
   localparam int MAX_MAG      = 32767;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_FIRST = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LAST  = 3'd7;

   typedef struct {
      logic signed [TEMP_WIDTH-1:0] temperature;
      logic [7:0]                   red;
      logic [7:0]                   green;
      logic [7:0]                   blue;
   } color_due_type;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_ready;
   logic signed [TEMP_WIDTH-1:0] req_temperature;
   logic                         rsp_valid;
   logic                         rsp_ready;
   logic [7:0]                   rsp_red;
   logic [7:0]                   rsp_green;
   logic [7:0]                   rsp_blue;
   logic                         csr_write_enable;
   logic [CSR_IDX_W-1:0]         csr_index;
   logic [CSR_DATA_W-1:0]        csr_data;

   cfg_type       shadow_cfg;
   color_due_type colors_due[$];
   int            mismatch_count;
   int            cycle_count;
   int            stall_request;
   bit            source_idle_en;
   bit            sink_idle_en;

   temperature_false_color_map dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_temperature  (req_temperature),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic int idle_cycles(input bit enabled);
      return enabled ? $urandom_range(0, 17) : 0;
   endfunction

   // top - round_half_up(slope * offset / span); zero span gives the end value
   function automatic logic [7:0] ramp_down(input logic [7:0] top, input logic [7:0] slope,
                                            input longint unsigned offset,
                                            input longint unsigned span);
      longint unsigned q;
      if (span == 0)
         return top - slope;
      q = (2 * slope * offset + span) / (2 * span);
      if (q > slope)
         q = slope;
      return top - q[7:0];
   endfunction

   function automatic color_due_type predict_color(input logic signed [TEMP_WIDTH-1:0] sample);
      color_due_type   c;
      longint unsigned raw, mag, t1, t2, t3;
      logic            pos;
      logic [7:0]      main_ch, green_ch, third_ch;
      c.temperature = sample;
      main_ch  = LEVEL_FULL;
      green_ch = LEVEL_FULL;
      third_ch = LEVEL_FULL;
      t1 = shadow_cfg.first;
      t2 = shadow_cfg.second;
      t3 = shadow_cfg.third;
      if (sample == 0) begin
         c.red   = LEVEL_FULL;
         c.green = LEVEL_FULL;
         c.blue  = LEVEL_FULL;
         return c;
      end
      pos = !sample[TEMP_WIDTH-1];
      raw = $unsigned(sample);
      // most negative sample keeps its full magnitude
      mag = pos ? raw : (64'd1 << TEMP_WIDTH) - raw;
      if (mag <= t1) begin
         third_ch = shadow_cfg.discrete ? LEVEL_ZERO :
                    ramp_down(LEVEL_FULL, SLOPE_FULL, mag, t1);
      end else begin
         third_ch = LEVEL_ZERO;
         if (mag <= t2) begin
            if (shadow_cfg.discrete)
               green_ch = (mag <= shadow_cfg.middle) ? LEVEL_HALF : LEVEL_ZERO;
            else
               green_ch = ramp_down(LEVEL_FULL, SLOPE_FULL, mag - t1, t2 - t1);
         end else begin
            green_ch = LEVEL_ZERO;
            if (mag <= t3)
               main_ch = shadow_cfg.discrete ? LEVEL_DISC_MAIN :
                         ramp_down(LEVEL_FULL, SLOPE_HIGH, mag - t2, t3 - t2);
            else
               main_ch = LEVEL_HALF;
         end
      end
      c.red   = pos ? main_ch : third_ch;
      c.green = green_ch;
      c.blue  = pos ? third_ch : main_ch;
      return c;
   endfunction

   // half the time lands on or next to a threshold, where the segment logic flips
   function automatic logic signed [TEMP_WIDTH-1:0] pick_temperature();
      int mag;
      int thr;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: begin
            case ($urandom_range(0, 3))
               0:       thr = shadow_cfg.first;
               1:       thr = shadow_cfg.middle;
               2:       thr = shadow_cfg.second;
               default: thr = shadow_cfg.third;
            endcase
            mag = thr + $urandom_range(0, 6) - 3;
            if (mag < 0)
               mag = 0;
            if (mag > MAX_MAG)
               mag = MAX_MAG;
            return TEMP_WIDTH'($urandom_range(0, 1) ? -mag : mag);
         end
         5, 6, 7: return TEMP_WIDTH'($urandom());
         8: begin
            mag = $urandom_range(0, shadow_cfg.first);
            return TEMP_WIDTH'($urandom_range(0, 1) ? -mag : mag);
         end
         default: begin
            case ($urandom_range(0, 4))
               0:       return TEMP_WIDTH'(0);
               1:       return TEMP_WIDTH'(1);
               2:       return TEMP_WIDTH'(-1);
               3:       return TEMP_WIDTH'(MAX_MAG);
               default: return TEMP_WIDTH'(-MAX_MAG - 1);
            endcase
         end
      endcase
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_sample(input logic signed [TEMP_WIDTH-1:0] sample);
      int gap;
      gap = idle_cycles(source_idle_en);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       = 1'b1;
      req_temperature = sample;
      do @(posedge clock); while (!req_ready);
      colors_due.push_back(predict_color(sample));
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_data         = data;
      @(posedge clock);
      case (idx)
         CSR_DISCRETE: shadow_cfg.discrete = data[0];
         CSR_FIRST:    shadow_cfg.first    = data;
         CSR_MIDDLE:   shadow_cfg.middle   = data;
         CSR_SECOND:   shadow_cfg.second   = data;
         CSR_THIRD:    shadow_cfg.third    = data;
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task automatic apply_settings(input logic disc, input int t1, input int mid,
                                 input int t2, input int t3);
      write_reg(CSR_DISCRETE, {{(CSR_DATA_W-1){1'b0}}, disc});
      write_reg(CSR_FIRST, CSR_DATA_W'(t1));
      write_reg(CSR_MIDDLE, CSR_DATA_W'(mid));
      write_reg(CSR_SECOND, CSR_DATA_W'(t2));
      write_reg(CSR_THIRD, CSR_DATA_W'(t3));
   endtask

   task automatic settle();
      req_valid = 1'b0;
      while (colors_due.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic send_random(input int count);
      for (int i = 0; i < count; i++)
         send_sample(pick_temperature());
   endtask

   task automatic test_discrete_levels();
      int picks [13] = '{0, 1, -1, 512, 513, -1280, 1281, 2560, 2561, 5120, 5121,
                         32767, -32768};
      source_idle_en = 1'b0;
      sink_idle_en   = 1'b0;
      foreach (picks[i])
         send_sample(TEMP_WIDTH'(picks[i]));
      settle();
   endtask

   task automatic test_linear_ramps();
      int picks [12] = '{1, 256, 511, 512, -513, 1536, 2559, -2560, 2561, 3840, 5120,
                         5121};
      // upper data bits set: only bit 0 counts for the mode register
      write_reg(CSR_DISCRETE, 15'h7FFE);
      source_idle_en = 1'b1;
      sink_idle_en   = 1'b1;
      foreach (picks[i])
         send_sample(TEMP_WIDTH'(picks[i]));
      settle();
   endtask

   task automatic test_register_extremes();
      int sets [5][4] = '{'{1, 1, 1, 1},
                          '{MAX_MAG, MAX_MAG, MAX_MAG, MAX_MAG},
                          '{3000, 4000, 1000, 2000},
                          '{0, 0, 0, 0},
                          '{100, 20000, 200, 300}};
      foreach (sets[s]) begin
         apply_settings(1'b1, sets[s][0], sets[s][1], sets[s][2], sets[s][3]);
         for (int disc = 1; disc >= 0; disc--) begin
            write_reg(CSR_DISCRETE, CSR_DATA_W'(disc));
            source_idle_en = 1'($urandom_range(0, 1));
            sink_idle_en   = 1'($urandom_range(0, 1));
            send_random(12);
            settle();
         end
      end
   endtask

   task automatic test_unused_index();
      apply_settings(1'b0, RST_FIRST, RST_MIDDLE, RST_SECOND, RST_THIRD);
      for (int idx = CSR_SPARE_FIRST; idx <= CSR_SPARE_LAST; idx++)
         write_reg(CSR_IDX_W'(idx), CSR_DATA_W'($urandom()));
      source_idle_en = 1'b1;
      sink_idle_en   = 1'b0;
      send_random(20);
      settle();
   endtask

   task automatic test_output_backpressure();
      source_idle_en = 1'b0;
      sink_idle_en   = 1'b0;
      stall_request  = 300;
      send_random(40);
      settle();
   endtask

   task automatic test_random_settings();
      int lim, a, b, c, tmp, mid;
      for (int phase = 0; phase < 11; phase++) begin
         case ($urandom_range(0, 2))
            0:       lim = 64;
            1:       lim = 1024;
            default: lim = MAX_MAG;
         endcase
         a = $urandom_range(0, lim);
         b = $urandom_range(0, lim);
         c = $urandom_range(0, lim);
         if ($urandom_range(0, 4) != 0) begin
            if (a > b) begin tmp = a; a = b; b = tmp; end
            if (b > c) begin tmp = b; b = c; c = tmp; end
            if (a > b) begin tmp = a; a = b; b = tmp; end
         end
         mid = ($urandom_range(0, 3) != 0) ? $urandom_range(a, b) : $urandom_range(0, MAX_MAG);
         apply_settings(1'($urandom_range(0, 1)), a, mid, b, c);
         source_idle_en = $urandom_range(0, 3) != 0;
         sink_idle_en   = $urandom_range(0, 3) != 0;
         send_random(45);
         settle();
      end
   endtask

   // result side: random ready gaps, plus a long hold-off on request
   initial begin
      int gap;
      int hold;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_request > 0) begin
            hold          = stall_request;
            stall_request = 0;
            rsp_ready     = 1'b0;
            repeat (hold) @(negedge clock);
         end
         gap = idle_cycles(sink_idle_en);
         if (gap > 0) begin
            rsp_ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin : check_result
      color_due_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (colors_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("unexpected item: rgb %0d %0d %0d", rsp_red, rsp_green, rsp_blue);
         end else begin
            want = colors_due.pop_front();
            if (rsp_red !== want.red || rsp_green !== want.green || rsp_blue !== want.blue) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("mismatch temp %0d: want rgb %0d %0d %0d, got %0d %0d %0d",
                           want.temperature, want.red, want.green, want.blue,
                           rsp_red, rsp_green, rsp_blue);
            end
         end
      end
   end

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_temperature  = '0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_DISCRETE;
      csr_data         = '0;
      mismatch_count   = 0;
      cycle_count      = 0;
      stall_request    = 0;
      source_idle_en   = 1'b0;
      sink_idle_en     = 1'b0;
      shadow_cfg       = '{RST_DISCRETE, RST_FIRST, RST_MIDDLE, RST_SECOND, RST_THIRD};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_discrete_levels();
      test_linear_ramps();
      test_register_extremes();
      test_unused_index();
      test_output_backpressure();
      test_random_settings();
      settle();

      if (mismatch_count == 0 && colors_due.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
